// File: hdl/channel_filtered_trace_record_fifo_macros.svh
// Assertion macros for the channel filtered trace record FIFO checker.
// Used by the checker file only; no other dependencies.
`ifndef CHANNEL_FILTERED_TRACE_RECORD_FIFO_MACROS_SVH
`define CHANNEL_FILTERED_TRACE_RECORD_FIFO_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CFTRF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cftrf check failed");

// Next-cycle implication, disabled during reset
`define CFTRF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cftrf check failed");

`endif

// File: hdl/cftrf_pkg.sv
// Shared types and constants of the channel filtered trace record FIFO.
// No dependencies; imported by the front, back and top level.
`timescale 1ns / 1ps

package cftrf_pkg;

   // Byte store depth and derived widths
   localparam int STORE_BYTES = 512;
   localparam int PTR_W       = $clog2(STORE_BYTES);
   localparam int USED_W      = $clog2(STORE_BYTES + 1);
   localparam int SUM_W       = $clog2(STORE_BYTES + 258);

   // Record counter
   localparam int REC_W = 9;
   localparam logic [REC_W-1:0] RECORDS_MAX = 9'd511;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Input mode codes
   typedef enum logic [1:0] {
      MODE_HEADER  = 2'd0,
      MODE_PAYLOAD = 2'd1,
      MODE_POP     = 2'd2,
      MODE_FLUSH   = 2'd3
   } mode_type;

   // Classified command handed from front to back
   typedef struct packed {
      mode_type   kind;
      logic       enabled;
      logic [7:0] chan_onehot;
      logic [7:0] length;
      logic [7:0] data;
   } cmd_type;

endpackage

// File: hdl/cftrf_front.sv
// Front end: takes input beats, classifies them and queues commands.
// Depends on cftrf_pkg.
`timescale 1ns / 1ps

module cftrf_front
   import cftrf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_mode,
   input  logic [2:0] req_channel,
   input  logic [7:0] req_record_length,
   input  logic [7:0] req_payload_byte,
   input  logic [7:0] enable_mask,
   output logic       cmd_valid,
   output cmd_type    cmd,
   input  logic       cmd_take
);

   cmd_type            queue_ff [QUEUE_DEPTH];
   logic [QIDX_W-1:0]  wr_idx_ff, wr_idx_in;
   logic [QIDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   cmd_type            new_cmd;
   logic               push;
   logic               pop;

   // Classify the incoming beat
   always_comb begin
      new_cmd.kind        = mode_type'(req_mode);
      new_cmd.enabled     = enable_mask[req_channel];
      new_cmd.chan_onehot = 8'(1) << req_channel;
      new_cmd.length      = req_record_length;
      new_cmd.data        = req_payload_byte;
   end

   assign busy      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push      = start && !busy;
   assign cmd_valid = (count_ff != '0);
   assign pop       = cmd_take && cmd_valid;
   assign cmd       = queue_ff[rd_idx_ff];

   // Queue pointers
   always_comb begin
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      count_in  = count_ff;
      if (push) begin
         wr_idx_in = (wr_idx_ff == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_idx_ff + 1'b1;
      end
      if (pop) begin
         rd_idx_in = (rd_idx_ff == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_idx_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_idx_ff] <= new_cmd;
      end
   end

endmodule

// File: hdl/cftrf_back.sv
// Back end: byte store, record bookkeeping and registered response.
// Depends on cftrf_pkg; takes commands from cftrf_front.
`timescale 1ns / 1ps

module cftrf_back
   import cftrf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   output logic        cmd_take,
   output logic        rsp_strobe,
   output logic        rsp_out_valid,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_record_end,
   output logic        rsp_accepted,
   output logic [8:0]  rsp_records_waiting,
   output logic [9:0]  rsp_bytes_used
);

   typedef enum logic [2:0] {
      ST_EXEC = 3'b001,
      ST_HDR2 = 3'b010,
      ST_POP2 = 3'b100
   } state_type;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'b001,
      PH_LENGTH  = 3'b010,
      PH_PAYLOAD = 3'b100
   } phase_type;

   logic [7:0]        store_mem [STORE_BYTES];

   state_type         state_ff, state_in;
   phase_type         phase_ff, phase_in;
   logic [PTR_W-1:0]  wp_ff, wp_in;
   logic [PTR_W-1:0]  rp_ff, rp_in;
   logic [USED_W-1:0] used_ff, used_in;
   logic [REC_W-1:0]  complete_ff, complete_in;
   logic              admitting_ff, admitting_in;
   logic [7:0]        left_in_ff, left_in_in;
   logic [7:0]        left_out_ff, left_out_in;
   logic [7:0]        hdr_len_ff, hdr_len_in;
   logic [7:0]        rd_data_ff;

   logic              mem_we;
   logic [7:0]        mem_wdata;
   logic              mem_re;
   logic [SUM_W-1:0]  fit_sum;
   logic              fits;
   logic [7:0]        left_dec;

   logic              emit;
   logic              r_valid, r_byte_end, r_acc;
   logic [7:0]        r_byte;

   logic              strobe_ff;
   logic              valid_ff, end_ff, acc_ff;
   logic [7:0]        byte_ff;

   function automatic logic [PTR_W-1:0] ptr_step(input logic [PTR_W-1:0] p);
      ptr_step = (p == PTR_W'(STORE_BYTES - 1)) ? '0 : p + 1'b1;
   endfunction

   // Space check for a new record: length plus channel and length bytes
   assign fit_sum  = SUM_W'(used_ff) + SUM_W'(cmd.length) + SUM_W'(2);
   assign fits     = (fit_sum <= SUM_W'(STORE_BYTES));
   assign left_dec = (left_out_ff != 8'd0) ? left_out_ff - 8'd1 : 8'd0;

   // Command execution
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      used_in      = used_ff;
      complete_in  = complete_ff;
      admitting_in = admitting_ff;
      left_in_in   = left_in_ff;
      left_out_in  = left_out_ff;
      hdr_len_in   = hdr_len_ff;
      mem_we       = 1'b0;
      mem_wdata    = cmd.chan_onehot;
      mem_re       = 1'b0;
      cmd_take     = 1'b0;
      emit         = 1'b0;
      r_valid      = 1'b0;
      r_byte       = 8'd0;
      r_byte_end   = 1'b0;
      r_acc        = 1'b0;

      case (state_ff)
         ST_EXEC: begin
            if (cmd_valid) begin
               cmd_take = 1'b1;
               case (cmd.kind)
                  MODE_HEADER: begin
                     emit = 1'b1;
                     if (!admitting_ff) begin
                        left_in_in = cmd.length;
                        if (cmd.enabled && fits && complete_ff != RECORDS_MAX) begin
                           // channel byte now, length byte next cycle
                           emit       = 1'b0;
                           mem_we     = 1'b1;
                           wp_in      = ptr_step(wp_ff);
                           used_in    = USED_W'(fit_sum);
                           hdr_len_in = cmd.length;
                           state_in   = ST_HDR2;
                        end
                     end
                  end
                  MODE_PAYLOAD: begin
                     emit = 1'b1;
                     if (admitting_ff) begin
                        r_acc      = 1'b1;
                        mem_we     = 1'b1;
                        mem_wdata  = cmd.data;
                        wp_in      = ptr_step(wp_ff);
                        left_in_in = left_in_ff - 8'd1;
                        if (left_in_ff == 8'd1) begin
                           admitting_in = 1'b0;
                           complete_in  = complete_ff + 1'b1;
                        end
                     end else if (left_in_ff != 8'd0) begin
                        left_in_in = left_in_ff - 8'd1;
                     end
                  end
                  MODE_POP: begin
                     if (complete_ff != '0) begin
                        mem_re   = 1'b1;
                        rp_in    = ptr_step(rp_ff);
                        if (used_ff != '0) begin
                           used_in = used_ff - 1'b1;
                        end
                        state_in = ST_POP2;
                     end else begin
                        emit = 1'b1;
                     end
                  end
                  MODE_FLUSH: begin
                     emit         = 1'b1;
                     wp_in        = '0;
                     rp_in        = '0;
                     used_in      = '0;
                     complete_in  = '0;
                     admitting_in = 1'b0;
                     left_in_in   = 8'd0;
                     phase_in     = PH_HEADER;
                     left_out_in  = 8'd0;
                  end
                  default: begin
                     emit = 1'b1;
                  end
               endcase
            end
         end
         ST_HDR2: begin
            // second header byte: the payload length
            emit      = 1'b1;
            r_acc     = 1'b1;
            mem_we    = 1'b1;
            mem_wdata = hdr_len_ff;
            wp_in     = ptr_step(wp_ff);
            if (hdr_len_ff == 8'd0) begin
               complete_in = complete_ff + 1'b1;
            end else begin
               admitting_in = 1'b1;
            end
            state_in = ST_EXEC;
         end
         ST_POP2: begin
            emit    = 1'b1;
            r_valid = 1'b1;
            r_byte  = rd_data_ff;
            case (phase_ff)
               PH_HEADER: begin
                  phase_in = PH_LENGTH;
               end
               PH_LENGTH: begin
                  left_out_in = rd_data_ff;
                  if (rd_data_ff == 8'd0) begin
                     phase_in   = PH_HEADER;
                     r_byte_end = 1'b1;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end
               PH_PAYLOAD: begin
                  left_out_in = left_dec;
                  if (left_dec == 8'd0) begin
                     phase_in   = PH_HEADER;
                     r_byte_end = 1'b1;
                  end
               end
               default: begin
                  phase_in = PH_HEADER;
               end
            endcase
            if (r_byte_end) begin
               complete_in = complete_ff - 1'b1;
            end
            state_in = ST_EXEC;
         end
         default: begin
            state_in = ST_EXEC;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_EXEC;
         phase_ff     <= PH_HEADER;
         wp_ff        <= '0;
         rp_ff        <= '0;
         used_ff      <= '0;
         complete_ff  <= '0;
         admitting_ff <= 1'b0;
         left_in_ff   <= 8'd0;
         left_out_ff  <= 8'd0;
         strobe_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         used_ff      <= used_in;
         complete_ff  <= complete_in;
         admitting_ff <= admitting_in;
         left_in_ff   <= left_in_in;
         left_out_ff  <= left_out_in;
         strobe_ff    <= emit;
      end
   end

   // Response payload and header length stash
   always_ff @(posedge clock) begin
      hdr_len_ff <= hdr_len_in;
      if (emit) begin
         valid_ff <= r_valid;
         byte_ff  <= r_byte;
         end_ff   <= r_byte_end;
         acc_ff   <= r_acc;
      end
   end

   // Byte store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[wp_ff] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= store_mem[rp_ff];
      end
   end

   // Counts are shown as they stand after the beat's command
   logic [REC_W-1:0]  rec_shown_ff;
   logic [USED_W-1:0] used_shown_ff;

   always_ff @(posedge clock) begin
      if (emit) begin
         rec_shown_ff  <= complete_in;
         used_shown_ff <= used_in;
      end
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_out_valid       = valid_ff;
   assign rsp_out_byte        = byte_ff;
   assign rsp_record_end      = end_ff;
   assign rsp_accepted        = acc_ff;
   assign rsp_records_waiting = 9'(rec_shown_ff);
   assign rsp_bytes_used      = 10'(used_shown_ff);

endmodule

// File: hdl/channel_filtered_trace_record_fifo.sv
// Top level of the channel filtered trace record FIFO.
// Depends on cftrf_pkg, cftrf_front and cftrf_back.
//
// Usage:
//   Input beats are taken on start while busy is low. req_mode selects a
//   record header, a payload byte, a pop of one byte or a flush.
//   Every beat gives exactly one response, shown for one cycle with
//   rsp_strobe high; the receiver cannot stall it.
//   csr_write_enable/csr_write_data load the channel enable mask; write it
//   only while no beat is outstanding.
// Timing:
//   A two-entry command queue parts the front from the back end, so busy
//   rises only when two beats are waiting. The back end handles a payload
//   byte, a flush, a rejected header or an empty pop in its execute state;
//   an admitted header also passes through ST_HDR2 (two store writes on
//   the single write port) and a pop of a byte through ST_POP2 (registered
//   store read). Each response is registered in the back end.
// Reset:
//   Synchronous reset empties the queue, pointers and counters and clears
//   the mask. Store contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module channel_filtered_trace_record_fifo
   import cftrf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_mode,
   input  logic [2:0] req_channel,
   input  logic [7:0] req_record_length,
   input  logic [7:0] req_payload_byte,
   output logic       rsp_strobe,
   output logic       rsp_out_valid,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_record_end,
   output logic       rsp_accepted,
   output logic [8:0] rsp_records_waiting,
   output logic [9:0] rsp_bytes_used,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);

   logic [7:0] enable_mask_ff, enable_mask_in;
   logic       cmd_valid;
   cmd_type    cmd;
   logic       cmd_take;

   // Channel enable mask register
   assign enable_mask_in = csr_write_enable ? csr_write_data : enable_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_mask_ff <= 8'd0;
      end else begin
         enable_mask_ff <= enable_mask_in;
      end
   end

   cftrf_front u_front (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_channel       (req_channel),
      .req_record_length (req_record_length),
      .req_payload_byte  (req_payload_byte),
      .enable_mask       (enable_mask_ff),
      .cmd_valid         (cmd_valid),
      .cmd               (cmd),
      .cmd_take          (cmd_take)
   );

   cftrf_back u_back (
      .clock               (clock),
      .reset               (reset),
      .cmd_valid           (cmd_valid),
      .cmd                 (cmd),
      .cmd_take            (cmd_take),
      .rsp_strobe          (rsp_strobe),
      .rsp_out_valid       (rsp_out_valid),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_record_end      (rsp_record_end),
      .rsp_accepted        (rsp_accepted),
      .rsp_records_waiting (rsp_records_waiting),
      .rsp_bytes_used      (rsp_bytes_used)
   );

endmodule

// File: hdl/cftrf_checker.sv
// Port-level checker for the channel filtered trace record FIFO, and its bind.
// Depends on channel_filtered_trace_record_fifo_macros.svh.
`timescale 1ns / 1ps
`include "channel_filtered_trace_record_fifo_macros.svh"

module cftrf_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_strobe,
   input logic       rsp_out_valid,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_record_end,
   input logic       rsp_accepted,
   input logic [9:0] rsp_bytes_used
);

   // A response without a popped byte carries no byte and no end mark
   `CFTRF_ASSERT_IMPL(a_no_byte_when_invalid, clock, reset, rsp_strobe && !rsp_out_valid, rsp_out_byte == 8'd0 && !rsp_record_end)

   // A popped byte never reports a store
   `CFTRF_ASSERT_IMPL(a_pop_not_accepted, clock, reset, rsp_strobe && rsp_out_valid, !rsp_accepted)

   // Record end only on a popped byte
   `CFTRF_ASSERT_IMPL(a_end_needs_byte, clock, reset, rsp_strobe && rsp_record_end, rsp_out_valid)

   // Used bytes never exceed the store
   `CFTRF_ASSERT_IMPL(a_used_in_range, clock, reset, rsp_strobe, rsp_bytes_used <= 10'd512)

endmodule

bind channel_filtered_trace_record_fifo cftrf_checker u_cftrf_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_strobe     (rsp_strobe),
   .rsp_out_valid  (rsp_out_valid),
   .rsp_out_byte   (rsp_out_byte),
   .rsp_record_end (rsp_record_end),
   .rsp_accepted   (rsp_accepted),
   .rsp_bytes_used (rsp_bytes_used)
);
